// File: hdl/qrs_pkg.sv
// Shared constants and types of the quadratic root solver.
package qrs_pkg;

	parameter int COEF_WIDTH_DEF = 32;
	parameter int FRAC_BITS_DEF  = 16;
	parameter int OUT_WIDTH      = 32;

	typedef enum logic [1:0] {
		KIND_DOUBLE  = 2'd0,
		KIND_TWO     = 2'd1,
		KIND_COMPLEX = 2'd2,
		KIND_AZERO   = 2'd3
	} kind_t;

	// Sign and case flags that follow an item from the discriminant stages.
	typedef struct packed {
		logic azero;
		logic dneg;
		logic a_neg;
		logic b_neg;
		logic c_neg;
	} disc_flags_t;

endpackage

// File: hdl/qrs_disc.sv
// Three-stage discriminant unit: magnitudes, products, then |b*b - 4ac| and its sign.
module qrs_disc
	import qrs_pkg::*;
#(
	parameter int W = COEF_WIDTH_DEF
) (
	input  logic                clk,
	input  logic                arst_n,
	input  logic                en,
	input  logic                in_valid,
	input  logic signed [W-1:0] a_coef,
	input  logic signed [W-1:0] b_coef,
	input  logic signed [W-1:0] c_coef,
	output logic                out_valid,
	output disc_flags_t         flags,
	output logic [2*W+1:0]      d_mag,
	output logic [W-1:0]        a_mag,
	output logic [W-1:0]        b_mag
);

	logic [W-1:0] a_u, b_u, c_u;
	logic         vld_s1, vld_s2, vld_s3;
	logic [W-1:0] am_s1, bm_s1, cm_s1, am_s2, bm_s2, am_s3, bm_s3;
	disc_flags_t  fl_s1, fl_s2, fl_s3;
	logic [2*W-1:0] b2_s2, ac_s2;
	logic [2*W+1:0] f4, b2x, d_s3;
	logic         opp, ge;

	assign a_u = a_coef;
	assign b_u = b_coef;
	assign c_u = c_coef;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			vld_s1 <= 1'b0;
			vld_s2 <= 1'b0;
			vld_s3 <= 1'b0;
		end else if (en) begin
			vld_s1 <= in_valid;
			vld_s2 <= vld_s1;
			vld_s3 <= vld_s2;
		end
	end

	assign f4  = {ac_s2, 2'b00};
	assign b2x = {2'b00, b2_s2};
	assign opp = fl_s2.a_neg ^ fl_s2.c_neg;
	assign ge  = (b2x >= f4);

	always_ff @(posedge clk) begin
		if (en) begin
			am_s1 <= a_u[W-1] ? (~a_u + 1'b1) : a_u;
			bm_s1 <= b_u[W-1] ? (~b_u + 1'b1) : b_u;
			cm_s1 <= c_u[W-1] ? (~c_u + 1'b1) : c_u;
			fl_s1.azero <= (a_u == '0);
			fl_s1.dneg  <= 1'b0;
			fl_s1.a_neg <= a_u[W-1];
			fl_s1.b_neg <= b_u[W-1];
			fl_s1.c_neg <= c_u[W-1];

			b2_s2 <= bm_s1 * bm_s1;
			ac_s2 <= am_s1 * cm_s1;
			am_s2 <= am_s1;
			bm_s2 <= bm_s1;
			fl_s2 <= fl_s1;

			if (opp) begin
				d_s3 <= b2x + f4;
			end else if (ge) begin
				d_s3 <= b2x - f4;
			end else begin
				d_s3 <= f4 - b2x;
			end
			am_s3 <= am_s2;
			bm_s3 <= bm_s2;
			fl_s3 <= {fl_s2.azero, !opp && !ge, fl_s2.a_neg, fl_s2.b_neg, fl_s2.c_neg};
		end
	end

	assign out_valid = vld_s3;
	assign flags     = fl_s3;
	assign d_mag     = d_s3;
	assign a_mag     = am_s3;
	assign b_mag     = bm_s3;

endmodule

// File: hdl/qrs_sqrt.sv
// Pipelined integer square root, one result bit per stage.
module qrs_sqrt #(
	parameter int IW = 66,
	parameter int SB = 8
) (
	input  logic            clk,
	input  logic            arst_n,
	input  logic            en,
	input  logic            in_valid,
	input  logic [IW-1:0]   in_rad,
	input  logic [SB-1:0]   in_sb,
	output logic            out_valid,
	output logic [IW/2-1:0] out_root,
	output logic [SB-1:0]   out_sb
);

	localparam int N = IW / 2;

	logic [IW-1:0] rad_s  [N];
	logic [IW-1:0] root_s [N];
	logic [SB-1:0] sb_s   [N];
	logic          vld_s  [N];

	for (genvar k = 0; k < N; k++) begin : g_step
		localparam logic [IW-1:0] BIT = {{(IW-1){1'b0}}, 1'b1} << (IW - 2 - 2 * k);
		logic [IW-1:0] rad_in, root_in, trial;
		logic [SB-1:0] sb_in;
		logic          v_in;

		if (k == 0) begin : g_first
			assign rad_in  = in_rad;
			assign root_in = '0;
			assign sb_in   = in_sb;
			assign v_in    = in_valid;
		end else begin : g_next
			assign rad_in  = rad_s[k-1];
			assign root_in = root_s[k-1];
			assign sb_in   = sb_s[k-1];
			assign v_in    = vld_s[k-1];
		end

		assign trial = root_in + BIT;

		always_ff @(posedge clk or negedge arst_n) begin
			if (!arst_n) begin
				vld_s[k] <= 1'b0;
			end else if (en) begin
				vld_s[k] <= v_in;
			end
		end

		always_ff @(posedge clk) begin
			if (en) begin
				if (rad_in >= trial) begin
					rad_s[k]  <= rad_in - trial;
					root_s[k] <= (root_in >> 1) + BIT;
				end else begin
					rad_s[k]  <= rad_in;
					root_s[k] <= root_in >> 1;
				end
				sb_s[k] <= sb_in;
			end
		end
	end

	assign out_valid = vld_s[N-1];
	assign out_root  = root_s[N-1][N-1:0];
	assign out_sb    = sb_s[N-1];

endmodule

// File: hdl/qrs_div.sv
// Pipelined restoring divider, one quotient bit per stage.
module qrs_div #(
	parameter int NW = 50,
	parameter int DW = 33,
	parameter int SB = 1
) (
	input  logic          clk,
	input  logic          arst_n,
	input  logic          en,
	input  logic          in_valid,
	input  logic [NW-1:0] in_num,
	input  logic [DW-1:0] in_den,
	input  logic [SB-1:0] in_sb,
	output logic          out_valid,
	output logic [NW-1:0] out_quo,
	output logic [SB-1:0] out_sb
);

	logic [DW-1:0] rem_s [NW];
	logic [NW-1:0] num_s [NW];
	logic [NW-1:0] quo_s [NW];
	logic [DW-1:0] den_s [NW];
	logic [SB-1:0] sb_s  [NW];
	logic          vld_s [NW];

	for (genvar k = 0; k < NW; k++) begin : g_step
		logic [DW-1:0] rem_in, den_in;
		logic [NW-1:0] num_in, quo_in;
		logic [SB-1:0] sb_in;
		logic          v_in;
		logic [DW:0]   sh, diff;

		if (k == 0) begin : g_first
			assign rem_in = '0;
			assign num_in = in_num;
			assign quo_in = '0;
			assign den_in = in_den;
			assign sb_in  = in_sb;
			assign v_in   = in_valid;
		end else begin : g_next
			assign rem_in = rem_s[k-1];
			assign num_in = num_s[k-1];
			assign quo_in = quo_s[k-1];
			assign den_in = den_s[k-1];
			assign sb_in  = sb_s[k-1];
			assign v_in   = vld_s[k-1];
		end

		assign sh   = {rem_in, num_in[NW-1]};
		assign diff = sh - {1'b0, den_in};

		always_ff @(posedge clk or negedge arst_n) begin
			if (!arst_n) begin
				vld_s[k] <= 1'b0;
			end else if (en) begin
				vld_s[k] <= v_in;
			end
		end

		always_ff @(posedge clk) begin
			if (en) begin
				if (sh >= {1'b0, den_in}) begin
					rem_s[k] <= diff[DW-1:0];
					quo_s[k] <= {quo_in[NW-2:0], 1'b1};
				end else begin
					rem_s[k] <= sh[DW-1:0];
					quo_s[k] <= {quo_in[NW-2:0], 1'b0};
				end
				num_s[k] <= num_in << 1;
				den_s[k] <= den_in;
				sb_s[k]  <= sb_in;
			end
		end
	end

	assign out_valid = vld_s[NW-1];
	assign out_quo   = quo_s[NW-1];
	assign out_sb    = sb_s[NW-1];

endmodule

// File: hdl/quadratic_root_solver.sv
// Top level of the quadratic root solver: discriminant, square root, numerator register, two dividers, output register.
//
// Usage: each input item carries the signed fixed-point coefficients a_coef,
// b_coef and c_coef of a*x^2 + b*x + c. Each item yields exactly one result item
// with root_kind (double real, two real, complex pair, or zero leading coefficient),
// first_value, second_value and the saturated flag. Both channels use valid/ready.
//
// The block is one long pipeline that takes a new item in every cycle unless
// the receiver stalls with a result in the output register. The depth is set
// by the square root, which resolves one root bit per stage, and by the two
// dividers, which resolve one quotient bit per stage and run side by side.
//
// All stages advance together on one enable. The pipeline moves whenever the
// output register is empty or is being taken, so in_ready stays high while a
// finished item waits only if that item is being taken. When the receiver
// stalls with a result in the output register, every stage holds its contents
// and in_ready drops; nothing is lost or repeated.
//
// Reset clears every valid bit, so no result item appears until an item enters.
module quadratic_root_solver
	import qrs_pkg::*;
#(
	parameter int COEF_WIDTH = COEF_WIDTH_DEF,
	parameter int FRAC_BITS  = FRAC_BITS_DEF
) (
	input  logic                         clk,
	input  logic                         arst_n,
	input  logic                         in_valid,
	output logic                         in_ready,
	input  logic signed [COEF_WIDTH-1:0] a_coef,
	input  logic signed [COEF_WIDTH-1:0] b_coef,
	input  logic signed [COEF_WIDTH-1:0] c_coef,
	output logic                         out_valid,
	input  logic                         out_ready,
	output logic [1:0]                   root_kind,
	output logic signed [OUT_WIDTH-1:0]  first_value,
	output logic signed [OUT_WIDTH-1:0]  second_value,
	output logic                         saturated
);

	localparam int W   = COEF_WIDTH;
	localparam int DDW = 2 * W + 2;            // discriminant magnitude width
	localparam int RW  = W + 1;                // square root width
	localparam int NSW = W + 3;                // signed numerator width
	localparam int MW  = W + 2;                // numerator magnitude width
	localparam int QW  = MW + FRAC_BITS;       // dividend and quotient width
	localparam int DVW = W + 1;                // divisor 2|a| width
	localparam int OW  = OUT_WIDTH;
	localparam int XW  = (QW > OW + 1) ? QW : OW + 1;
	localparam int FW  = $bits(disc_flags_t);
	localparam int SQB = FW + 2 * W;

	// One enable for every stage: move unless a result waits in the output register.
	logic en;
	assign en       = !out_valid || out_ready;
	assign in_ready = en;

	// Discriminant stages.
	logic          dc_valid;
	disc_flags_t   dc_flags;
	logic [DDW-1:0] dc_d;
	logic [W-1:0]  dc_am, dc_bm;

	qrs_disc #(.W(W)) u_disc (
		.clk      (clk),
		.arst_n   (arst_n),
		.en       (en),
		.in_valid (in_valid),
		.a_coef   (a_coef),
		.b_coef   (b_coef),
		.c_coef   (c_coef),
		.out_valid(dc_valid),
		.flags    (dc_flags),
		.d_mag    (dc_d),
		.a_mag    (dc_am),
		.b_mag    (dc_bm)
	);

	// Square root of the discriminant magnitude; flags and magnitudes ride alongside.
	logic           sq_valid;
	logic [RW-1:0]  sq_root;
	logic [SQB-1:0] sq_sb;
	disc_flags_t    sq_flags;
	logic [W-1:0]   sq_am, sq_bm;

	qrs_sqrt #(.IW(DDW), .SB(SQB)) u_sqrt (
		.clk      (clk),
		.arst_n   (arst_n),
		.en       (en),
		.in_valid (dc_valid),
		.in_rad   (dc_d),
		.in_sb    ({dc_flags, dc_am, dc_bm}),
		.out_valid(sq_valid),
		.out_root (sq_root),
		.out_sb   (sq_sb)
	);

	assign {sq_flags, sq_am, sq_bm} = sq_sb;

	// Numerator preparation. A double root has a zero square root, so it shares
	// the two-real-root numerators; a complex pair divides -b and the root.
	kind_t          kind_c;
	logic [NSW-1:0] s_x, nb, n1, n2;
	logic           neg1_c, neg2_c;
	logic [MW-1:0]  mag1_c, mag2_c;

	always_comb begin
		priority if (sq_flags.azero) begin
			kind_c = KIND_AZERO;
		end else if (sq_flags.dneg) begin
			kind_c = KIND_COMPLEX;
		end else if (sq_root == '0) begin
			kind_c = KIND_DOUBLE;
		end else begin
			kind_c = KIND_TWO;
		end
	end

	assign s_x = {2'b00, sq_root};
	assign nb  = sq_flags.b_neg ? {3'b000, sq_bm} : (~{3'b000, sq_bm} + 1'b1);
	assign n1  = (kind_c == KIND_TWO) ? (nb + s_x) : nb;
	assign n2  = (kind_c == KIND_COMPLEX) ? s_x : (nb - s_x);

	always_comb begin
		logic [NSW-1:0] m1, m2;
		m1     = n1[NSW-1] ? (~n1 + 1'b1) : n1;
		m2     = n2[NSW-1] ? (~n2 + 1'b1) : n2;
		mag1_c = m1[MW-1:0];
		mag2_c = m2[MW-1:0];
		neg1_c = (n1[NSW-1] != sq_flags.a_neg) && (n1 != '0);
		neg2_c = (kind_c != KIND_COMPLEX) && (n2[NSW-1] != sq_flags.a_neg) && (n2 != '0);
	end

	logic           vld_sp;
	kind_t          kind_sp;
	logic           neg1_sp, neg2_sp;
	logic [MW-1:0]  mag1_sp, mag2_sp;
	logic [DVW-1:0] den_sp;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			vld_sp <= 1'b0;
		end else if (en) begin
			vld_sp <= sq_valid;
		end
	end

	always_ff @(posedge clk) begin
		if (en) begin
			kind_sp <= kind_c;
			neg1_sp <= neg1_c;
			neg2_sp <= neg2_c;
			mag1_sp <= mag1_c;
			mag2_sp <= mag2_c;
			den_sp  <= {sq_am, 1'b0};
		end
	end

	// Two dividers in lockstep; the first carries the kind and its sign.
	logic          dv1_valid;
	logic [QW-1:0] q1, q2;
	logic [2:0]    dv1_sb;
	logic          dv2_sb;

	qrs_div #(.NW(QW), .DW(DVW), .SB(3)) u_div1 (
		.clk      (clk),
		.arst_n   (arst_n),
		.en       (en),
		.in_valid (vld_sp),
		.in_num   ({mag1_sp, {FRAC_BITS{1'b0}}}),
		.in_den   (den_sp),
		.in_sb    ({kind_sp, neg1_sp}),
		.out_valid(dv1_valid),
		.out_quo  (q1),
		.out_sb   (dv1_sb)
	);

	qrs_div #(.NW(QW), .DW(DVW), .SB(1)) u_div2 (
		.clk      (clk),
		.arst_n   (arst_n),
		.en       (en),
		.in_valid (vld_sp),
		.in_num   ({mag2_sp, {FRAC_BITS{1'b0}}}),
		.in_den   (den_sp),
		.in_sb    (neg2_sp),
		.out_valid(),
		.out_quo  (q2),
		.out_sb   (dv2_sb)
	);

	// Signing and saturation to the output width.
	kind_t         kind_d;
	logic [XW-1:0] qx1, qx2;
	logic [OW-1:0] v1_c, v2_c;
	logic          sat1_c, sat2_c;

	assign kind_d = kind_t'(dv1_sb[2:1]);
	assign qx1    = XW'(q1);
	assign qx2    = XW'(q2);

	always_comb begin
		if (!dv1_sb[0]) begin
			sat1_c = |qx1[XW-1:OW-1];
			v1_c   = sat1_c ? {1'b0, {(OW-1){1'b1}}} : qx1[OW-1:0];
		end else begin
			sat1_c = (|qx1[XW-1:OW]) || (qx1[OW-1] && (|qx1[OW-2:0]));
			v1_c   = sat1_c ? {1'b1, {(OW-1){1'b0}}} : (~qx1[OW-1:0] + 1'b1);
		end
		if (!dv2_sb) begin
			sat2_c = |qx2[XW-1:OW-1];
			v2_c   = sat2_c ? {1'b0, {(OW-1){1'b1}}} : qx2[OW-1:0];
		end else begin
			sat2_c = (|qx2[XW-1:OW]) || (qx2[OW-1] && (|qx2[OW-2:0]));
			v2_c   = sat2_c ? {1'b1, {(OW-1){1'b0}}} : (~qx2[OW-1:0] + 1'b1);
		end
	end

	// Output register.
	logic          vld_so;
	kind_t         kind_so;
	logic [OW-1:0] v1_so, v2_so;
	logic          sat_so;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			vld_so <= 1'b0;
		end else if (en) begin
			vld_so <= dv1_valid;
		end
	end

	always_ff @(posedge clk) begin
		if (en) begin
			kind_so <= kind_d;
			if (kind_d == KIND_AZERO) begin
				v1_so  <= '0;
				v2_so  <= '0;
				sat_so <= 1'b0;
			end else begin
				v1_so  <= v1_c;
				v2_so  <= v2_c;
				sat_so <= sat1_c || sat2_c;
			end
		end
	end

	assign out_valid    = vld_so;
	assign root_kind    = kind_so;
	assign first_value  = v1_so;
	assign second_value = v2_so;
	assign saturated    = sat_so;

endmodule

// File: hdl/qrs_chk.sv
// Port-level checker for the quadratic root solver and its bind.
module qrs_chk
	import qrs_pkg::*;
(
	input logic                        clk,
	input logic                        arst_n,
	input logic                        in_ready,
	input logic                        out_valid,
	input logic                        out_ready,
	input logic [1:0]                  root_kind,
	input logic signed [OUT_WIDTH-1:0] first_value,
	input logic signed [OUT_WIDTH-1:0] second_value,
	input logic                        saturated
);

	a_hold: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && !out_ready |=> out_valid && $stable(first_value)
			&& $stable(second_value) && $stable(root_kind) && $stable(saturated))
		else $error("result item changed while stalled");

	a_free: assert property (@(posedge clk) disable iff (!arst_n)
		!out_valid |-> in_ready)
		else $error("input stalled with an empty output register");

	a_azero: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && root_kind == KIND_AZERO |->
			first_value == '0 && second_value == '0 && !saturated)
		else $error("zero leading coefficient gave nonzero values");

	a_double: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && root_kind == KIND_DOUBLE |-> first_value == second_value)
		else $error("double root values differ");

	a_imag: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && root_kind == KIND_COMPLEX |-> !second_value[OUT_WIDTH-1])
		else $error("negative imaginary magnitude");

endmodule

bind quadratic_root_solver qrs_chk u_qrs_chk (.*);
